FILE: rtl/i8mm_pkg.sv
// Shared widths, field positions, codes and interface structs of the int8 tile multiplier.
package i8mm_pkg;

	localparam int WIDX_W     = 10;
	localparam int DATA_W     = 32;
	localparam int TILE_W     = 4;
	localparam int DIM_W      = 7;
	localparam int SUM_W      = 32;
	localparam int POS_W      = 6;
	localparam int KIND_W     = 2;
	// widest store address over the MAX_DIM range (256*256/4 words)
	localparam int ADDR_W_MAX = 14;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam int IN_WIDX_LSB = 0;
	localparam int IN_DATA_LSB = IN_WIDX_LSB + WIDX_W;
	localparam int IN_TROW_LSB = IN_DATA_LSB + DATA_W;
	localparam int IN_TCOL_LSB = IN_TROW_LSB + TILE_W;
	localparam int IN_TDATA_W  = 56;

	localparam int OUT_SUM_LSB = 0;
	localparam int OUT_ROW_LSB = OUT_SUM_LSB + SUM_W;
	localparam int OUT_COL_LSB = OUT_ROW_LSB + POS_W;
	localparam int OUT_TDATA_W = 48;

	localparam logic [KIND_W-1:0] KIND_WR_A = 2'd0;
	localparam logic [KIND_W-1:0] KIND_WR_B = 2'd1;
	localparam logic [KIND_W-1:0] KIND_TILE = 2'd2;

	typedef logic [ADDR_W_MAX-1:0] addr_t;

	typedef struct packed {
		logic [DIM_W-1:0] rows_a;
		logic [DIM_W-1:0] inner_len;
		logic [DIM_W-1:0] cols_b;
	} dims_t;

	typedef struct packed {
		logic             wr_a;
		logic             wr_b;
		logic             rd_en;
		logic             rd_last;
		addr_t            a_addr;
		addr_t            b_addr;
		logic             acc_clr;
		logic             mac_en;
		logic [1:0]       mac_row;
		logic             emit_en;
		logic             emit_last;
		logic [POS_W-1:0] emit_row;
		logic [POS_W-1:0] emit_col;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_stat_t;

endpackage

FILE: rtl/i8mm_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module i8mm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/i8mm_cfg.sv
// APB register file holding the three matrix dimension registers.
module i8mm_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [i8mm_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [i8mm_pkg::APB_DATA_W-1:0] pwdata,
	output logic [i8mm_pkg::APB_DATA_W-1:0] prdata,
	output logic                             pready,
	output i8mm_pkg::dims_t                  dims
);
	import i8mm_pkg::*;

	localparam logic [1:0] REG_ROWS_A    = 2'd0;
	localparam logic [1:0] REG_INNER_LEN = 2'd1;
	localparam logic [1:0] REG_COLS_B    = 2'd2;
	localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

	logic [DIM_W-1:0] rows_a_q;
	logic [DIM_W-1:0] inner_len_q;
	logic [DIM_W-1:0] cols_b_q;
	logic             wr_en;
	logic [1:0]       reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= DIM_RESET;
			inner_len_q <= DIM_RESET;
			cols_b_q    <= DIM_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_ROWS_A:    rows_a_q    <= pwdata[DIM_W-1:0];
				REG_INNER_LEN: inner_len_q <= pwdata[DIM_W-1:0];
				REG_COLS_B:    cols_b_q    <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ROWS_A:    prdata = {{(APB_DATA_W-DIM_W){1'b0}}, rows_a_q};
			REG_INNER_LEN: prdata = {{(APB_DATA_W-DIM_W){1'b0}}, inner_len_q};
			REG_COLS_B:    prdata = {{(APB_DATA_W-DIM_W){1'b0}}, cols_b_q};
			default:       prdata = '0;
		endcase
	end

	assign dims.rows_a    = rows_a_q;
	assign dims.inner_len = inner_len_q;
	assign dims.cols_b    = cols_b_q;

endmodule

FILE: rtl/i8mm_ctrl.sv
// Controller: input decode, store address sequencing, MAC and emit scheduling.
module i8mm_ctrl #(
	parameter int MAX_DIM = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [i8mm_pkg::KIND_W-1:0] kind,
	input  logic [i8mm_pkg::WIDX_W-1:0] word_index,
	input  logic [i8mm_pkg::TILE_W-1:0] tile_row,
	input  logic [i8mm_pkg::TILE_W-1:0] tile_col,
	input  i8mm_pkg::dims_t              dims,
	output i8mm_pkg::dp_cmd_t            cmd,
	input  i8mm_pkg::dp_stat_t           stat
);
	import i8mm_pkg::*;

	localparam int STORE_DEPTH = MAX_DIM * MAX_DIM / 4;
	localparam logic [2:0] DRAIN_MACS = 3'd4;
	localparam logic [2:0] DRAIN_LAST = 3'd5;
	localparam logic [3:0] EMIT_LAST  = 4'd15;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_READ  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
			input int unsigned max_dim);
		logic [DIM_W-1:0] d;
		d = {v[DIM_W-1:2], 2'b00};
		if (d < 7'd4) d = 7'd4;
		if (32'(d) > max_dim) d = max_dim[DIM_W-1:0];
		return d;
	endfunction

	state_t           st_q;
	logic [4:0]       kb_q;
	logic [1:0]       j_q;
	logic [2:0]       dcnt_q;
	logic [3:0]       e_q;
	addr_t            a_base_q;
	addr_t            b_addr_q;
	logic [TILE_W-1:0] tr_q;
	logic [TILE_W-1:0] tc_q;

	logic [DIM_W-1:0] nr, nk, nc;
	logic [4:0]       k4, c4;
	logic             accept, widx_ok, tile_ok, start;

	assign nr = eff_dim(dims.rows_a, MAX_DIM);
	assign nk = eff_dim(dims.inner_len, MAX_DIM);
	assign nc = eff_dim(dims.cols_b, MAX_DIM);
	assign k4 = nk[DIM_W-1:2];
	assign c4 = nc[DIM_W-1:2];

	assign s_tready = (st_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign widx_ok  = 32'(word_index) < 32'(STORE_DEPTH);
	assign tile_ok  = (7'({tile_row, 2'b00}) < nr) && (7'({tile_col, 2'b00}) < nc);
	assign start    = accept && (kind == KIND_TILE) && tile_ok;

	always_comb begin
		cmd           = '0;
		cmd.a_addr    = a_base_q + addr_t'(7'(j_q) * 7'(k4));
		cmd.b_addr    = b_addr_q;
		cmd.emit_row  = {tr_q, e_q[3:2]};
		cmd.emit_col  = {tc_q, e_q[1:0]};
		cmd.emit_last = (e_q == EMIT_LAST);
		unique case (st_q)
			ST_IDLE: begin
				cmd.wr_a    = accept && (kind == KIND_WR_A) && widx_ok;
				cmd.wr_b    = accept && (kind == KIND_WR_B) && widx_ok;
				cmd.acc_clr = start;
			end
			ST_READ: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_last = (j_q == 2'd3);
				// rows of the previous word block run while this one is fetched
				cmd.mac_en  = (kb_q != 5'd0);
				cmd.mac_row = j_q;
			end
			ST_DRAIN: begin
				cmd.mac_en  = (dcnt_q < DRAIN_MACS);
				cmd.mac_row = dcnt_q[1:0];
			end
			ST_EMIT: begin
				cmd.emit_en = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_IDLE;
			kb_q   <= '0;
			j_q    <= '0;
			dcnt_q <= '0;
			e_q    <= '0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (start) begin
						st_q <= ST_READ;
						kb_q <= '0;
						j_q  <= '0;
					end
				end
				ST_READ: begin
					j_q <= j_q + 2'd1;
					if (j_q == 2'd3) begin
						kb_q <= kb_q + 5'd1;
						if (kb_q == 5'(k4 - 5'd1)) begin
							st_q   <= ST_DRAIN;
							dcnt_q <= '0;
						end
					end
				end
				ST_DRAIN: begin
					dcnt_q <= dcnt_q + 3'd1;
					if (dcnt_q == DRAIN_LAST) begin
						st_q <= ST_EMIT;
						e_q  <= '0;
					end
				end
				ST_EMIT: begin
					if (stat.out_free) begin
						e_q <= e_q + 4'd1;
						if (e_q == EMIT_LAST) st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// address bases and tile origin
	always_ff @(posedge clk) begin
		if (start) begin
			a_base_q <= addr_t'(11'(tile_row) * 11'(nk));
			b_addr_q <= addr_t'(tile_col);
			tr_q     <= tile_row;
			tc_q     <= tile_col;
		end else if (st_q == ST_READ) begin
			b_addr_q <= b_addr_q + addr_t'(c4);
			// next word block of the same four A rows
			if (j_q == 2'd3) a_base_q <= a_base_q + addr_t'(1'b1);
		end
	end

endmodule

FILE: rtl/i8mm_dp.sv
// Datapath: A and B stores, word buffers, quad byte MAC array, accumulators, output register.
module i8mm_dp #(
	parameter int MAX_DIM = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  i8mm_pkg::dp_cmd_t            cmd,
	output i8mm_pkg::dp_stat_t           stat,
	input  logic [i8mm_pkg::WIDX_W-1:0] word_index,
	input  logic [i8mm_pkg::DATA_W-1:0] packed_bytes,
	input  logic                         m_tready,
	output logic                         out_valid,
	output logic [i8mm_pkg::SUM_W-1:0]  out_sum,
	output logic [i8mm_pkg::POS_W-1:0]  out_row,
	output logic [i8mm_pkg::POS_W-1:0]  out_col,
	output logic                         out_last
);
	import i8mm_pkg::*;

	localparam int STORE_DEPTH = MAX_DIM * MAX_DIM / 4;
	localparam int AW          = $clog2(STORE_DEPTH);

	function automatic logic signed [7:0] lane_byte(input logic [31:0] w,
			input logic [1:0] lane);
		return w[{lane, 3'b000} +: 8];
	endfunction

	logic [AW+WIDX_W-1:0] widx_ext;
	logic [AW-1:0]        wr_addr;
	logic [DATA_W-1:0]    a_rdata, b_rdata;

	logic                 rd_s1, rd_last_s1;
	logic [DATA_W-1:0]    a_sh_q [0:2];
	logic [DATA_W-1:0]    b_sh_q [0:2];
	logic [DATA_W-1:0]    a_cur_q [0:3];
	logic [DATA_W-1:0]    b_cur_q [0:3];

	logic                 mac_v_s1, mac_v_s2;
	logic [1:0]           mac_row_s1, mac_row_s2;
	logic signed [15:0]   prod_d [0:3][0:3];
	logic signed [15:0]   prod_s2 [0:3][0:3];
	logic signed [17:0]   colsum [0:3];
	logic [SUM_W-1:0]     acc_q [0:15];

	logic                 emit_take;
	logic                 out_v_q, out_last_q;
	logic [SUM_W-1:0]     out_sum_q;
	logic [POS_W-1:0]     out_row_q, out_col_q;

	assign widx_ext = {{AW{1'b0}}, word_index};
	assign wr_addr  = widx_ext[AW-1:0];

	i8mm_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_a_store (
		.clk   (clk),
		.we    (cmd.wr_a),
		.waddr (wr_addr),
		.wdata (packed_bytes),
		.re    (cmd.rd_en),
		.raddr (cmd.a_addr[AW-1:0]),
		.rdata (a_rdata)
	);

	i8mm_ram #(.WIDTH(DATA_W), .DEPTH(STORE_DEPTH)) u_b_store (
		.clk   (clk),
		.we    (cmd.wr_b),
		.waddr (wr_addr),
		.wdata (packed_bytes),
		.re    (cmd.rd_en),
		.raddr (cmd.b_addr[AW-1:0]),
		.rdata (b_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1      <= 1'b0;
			rd_last_s1 <= 1'b0;
			mac_v_s1   <= 1'b0;
			mac_v_s2   <= 1'b0;
		end else begin
			rd_s1      <= cmd.rd_en;
			rd_last_s1 <= cmd.rd_last;
			mac_v_s1   <= cmd.mac_en;
			mac_v_s2   <= mac_v_s1;
		end
	end

	// collect a block of four words; hand it to the MAC side on the last one
	always_ff @(posedge clk) begin
		mac_row_s1 <= cmd.mac_row;
		mac_row_s2 <= mac_row_s1;
		if (rd_s1) begin
			if (rd_last_s1) begin
				a_cur_q[0] <= a_sh_q[0];
				a_cur_q[1] <= a_sh_q[1];
				a_cur_q[2] <= a_sh_q[2];
				a_cur_q[3] <= a_rdata;
				b_cur_q[0] <= b_sh_q[0];
				b_cur_q[1] <= b_sh_q[1];
				b_cur_q[2] <= b_sh_q[2];
				b_cur_q[3] <= b_rdata;
			end else begin
				a_sh_q[2] <= a_rdata;
				a_sh_q[1] <= a_sh_q[2];
				a_sh_q[0] <= a_sh_q[1];
				b_sh_q[2] <= b_rdata;
				b_sh_q[1] <= b_sh_q[2];
				b_sh_q[0] <= b_sh_q[1];
			end
		end
	end

	// one A row against the four B rows: sixteen byte products
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int l = 0; l < 4; l++) begin
				prod_d[c][l] = lane_byte(a_cur_q[mac_row_s1], 2'(l))
					* lane_byte(b_cur_q[l], 2'(c));
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 4; c++) begin
			for (int l = 0; l < 4; l++) begin
				prod_s2[c][l] <= prod_d[c][l];
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			colsum[c] = 18'(prod_s2[c][0]) + 18'(prod_s2[c][1])
				+ 18'(prod_s2[c][2]) + 18'(prod_s2[c][3]);
		end
	end

	assign stat.out_free = !out_v_q || m_tready;
	assign emit_take     = cmd.emit_en && stat.out_free;

	// accumulators in row-major order; emission shifts them toward entry zero
	always_ff @(posedge clk) begin
		if (cmd.acc_clr) begin
			for (int i = 0; i < 16; i++) acc_q[i] <= '0;
		end else if (mac_v_s2) begin
			for (int i = 0; i < 16; i++) begin
				if (2'(i / 4) == mac_row_s2) begin
					acc_q[i] <= acc_q[i] + 32'(colsum[i % 4]);
				end
			end
		end else if (emit_take) begin
			for (int i = 0; i < 15; i++) acc_q[i] <= acc_q[i + 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (emit_take) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_take) begin
			out_sum_q  <= acc_q[0];
			out_row_q  <= cmd.emit_row;
			out_col_q  <= cmd.emit_col;
			out_last_q <= cmd.emit_last;
		end
	end

	assign out_valid = out_v_q;
	assign out_sum   = out_sum_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign out_last  = out_last_q;

endmodule

FILE: rtl/int8_tiled_matrix_multiply.sv
// Top level of the signed int8 tiled matrix multiplier (C = A x B, 4x4 output tiles).
//
// Input stream (s_*): tuser carries the kind. Kind 0 writes the packed word into the
// A store, kind 1 into the B store, both at word_index. Kind 2 computes the 4x4 tile
// at (tile_row, tile_col); a tile outside the matrix and kind 3 are dropped.
// Dimensions come from the APB registers and must stay unchanged while a tile is
// in flight.
// A tile fetches one A word and one B word per cycle from single-read-port stores,
// followed by a MAC drain and 16 result beats on m_*. s_tready stays low from the
// compute beat until the sixteenth sum is in the output register. Results run
// row-major, tlast on the sixteenth.
// The output register holds a beat while m_tready is low and the emit sequence
// waits on it; nothing is lost.
// Reset clears the controller and the output valid and sets the dimensions to 64;
// store contents stay undefined until written.
module int8_tiled_matrix_multiply #(
	parameter int MAX_DIM = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// word_index[9:0], packed_bytes[41:10], tile_row[45:42], tile_col[49:46], zero pad
	input  logic [i8mm_pkg::IN_TDATA_W-1:0]   s_tdata,
	// kind[1:0]
	input  logic [i8mm_pkg::KIND_W-1:0]       s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// sum_value[31:0], out_row[37:32], out_col[43:38], zero pad
	output logic [i8mm_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic                               m_tlast,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [i8mm_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [i8mm_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [i8mm_pkg::APB_DATA_W-1:0]   prdata,
	output logic                               pready
);
	import i8mm_pkg::*;

	dims_t             dims;
	dp_cmd_t           cmd;
	dp_stat_t          stat;
	logic [WIDX_W-1:0] word_index;
	logic [DATA_W-1:0] packed_bytes;
	logic [TILE_W-1:0] tile_row, tile_col;
	logic [SUM_W-1:0]  out_sum;
	logic [POS_W-1:0]  out_row, out_col;

	assign word_index   = s_tdata[IN_WIDX_LSB +: WIDX_W];
	assign packed_bytes = s_tdata[IN_DATA_LSB +: DATA_W];
	assign tile_row     = s_tdata[IN_TROW_LSB +: TILE_W];
	assign tile_col     = s_tdata[IN_TCOL_LSB +: TILE_W];

	i8mm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.dims    (dims)
	);

	i8mm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.kind       (s_tuser),
		.word_index (word_index),
		.tile_row   (tile_row),
		.tile_col   (tile_col),
		.dims       (dims),
		.cmd        (cmd),
		.stat       (stat)
	);

	i8mm_dp #(.MAX_DIM(MAX_DIM)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.word_index   (word_index),
		.packed_bytes (packed_bytes),
		.m_tready     (m_tready),
		.out_valid    (m_tvalid),
		.out_sum      (out_sum),
		.out_row      (out_row),
		.out_col      (out_col),
		.out_last     (m_tlast)
	);

	assign m_tdata = {{(OUT_TDATA_W - SUM_W - 2 * POS_W){1'b0}}, out_col, out_row, out_sum};

endmodule

FILE: rtl/i8mm_checker.sv
// Port-level checks on the int8 tile multiplier, bound to the top level.
module i8mm_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_tvalid,
	input logic                               s_tready,
	input logic [i8mm_pkg::IN_TDATA_W-1:0]   s_tdata,
	input logic [i8mm_pkg::KIND_W-1:0]       s_tuser,
	input logic                               m_tvalid,
	input logic                               m_tready,
	input logic [i8mm_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input logic                               m_tlast
);
	import i8mm_pkg::*;

	logic origin_tile;

	// the origin tile always lies inside the matrix
	assign origin_tile = s_tvalid && s_tready && (s_tuser == KIND_TILE)
		&& (s_tdata[IN_TROW_LSB +: TILE_W] == '0)
		&& (s_tdata[IN_TCOL_LSB +: TILE_W] == '0);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result beat changed");

	a_busy_after_tile: assert property (@(posedge clk) disable iff (!arst_n)
		origin_tile |=> !s_tready)
		else $error("input accepted right after a compute beat");

	a_tile_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("gap inside a tile's result burst");

	a_no_input_mid_tile: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input ready while a tile is still emitting");

	a_idle_in_reset: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("result beat valid coming out of reset");

endmodule

bind int8_tiled_matrix_multiply i8mm_checker u_i8mm_checker (.*);

FILE: bench/tb_int8_tiled_matrix_multiply.sv
// Testbench for the int8 tiled matrix multiplier: stream stimulus, APB setup, result scoreboard.
module tb_int8_tiled_matrix_multiply;
	import i8mm_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int STORE_WORDS = 1 << WIDX_W;
	// low words of each store written up front; random dimensions stay inside them
	localparam int FILL_WORDS = 32;
	// settle allowance for the worst tile: fetch of inner_len words, drain and output
	localparam int TILE_LATENCY = 100;
	localparam int CYCLE_LIMIT = 300000;

	typedef enum int {
		REG_ROWS_A    = 0,
		REG_INNER_LEN = 1,
		REG_COLS_B    = 2
	} dim_reg_e;

	typedef struct packed {
		logic [SUM_W-1:0] sum;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
		logic             last;
	} c_elem_t;

	class matmul_predictor;
		logic [DATA_W-1:0] a_words [STORE_WORDS];
		logic [DATA_W-1:0] b_words [STORE_WORDS];
		int rows_eff = 64;
		int inner_eff = 64;
		int cols_eff = 64;
		c_elem_t pending_sums [$];
		int mismatches = 0;
		int sums_checked = 0;
		int tiles_run = 0;
		int words_written = 0;

		function int eff_dim(logic [DIM_W-1:0] v);
			int d;
			d = int'(v) & ~3;
			if (d < 4) d = 4;
			if (d > 64) d = 64;
			return d;
		endfunction

		function void set_dim(dim_reg_e idx, logic [DIM_W-1:0] v);
			case (idx)
				REG_ROWS_A: rows_eff = eff_dim(v);
				REG_INNER_LEN: inner_eff = eff_dim(v);
				REG_COLS_B: cols_eff = eff_dim(v);
				default: ;
			endcase
		endfunction

		function void note_beat(logic [KIND_W-1:0] kind, logic [WIDX_W-1:0] widx,
				logic [DATA_W-1:0] word, logic [TILE_W-1:0] tr, logic [TILE_W-1:0] tc);
			int row0, col0, k4, c4;
			int acc [4][4];
			logic [DATA_W-1:0] aw [4];
			logic [DATA_W-1:0] bw [4];
			byte av, bv;
			c_elem_t e;
			case (kind)
				KIND_WR_A: begin
					a_words[widx] = word;
					words_written++;
				end
				KIND_WR_B: begin
					b_words[widx] = word;
					words_written++;
				end
				KIND_TILE: begin
					row0 = int'(tr) * 4;
					col0 = int'(tc) * 4;
					if (row0 >= rows_eff || col0 >= cols_eff) return;
					k4 = inner_eff / 4;
					c4 = cols_eff / 4;
					for (int r = 0; r < 4; r++)
						for (int c = 0; c < 4; c++)
							acc[r][c] = 0;
					for (int kb = 0; kb < k4; kb++) begin
						for (int r = 0; r < 4; r++) begin
							aw[r] = a_words[(row0 + r) * k4 + kb];
							bw[r] = b_words[(kb * 4 + r) * c4 + int'(tc)];
						end
						for (int r = 0; r < 4; r++)
							for (int c = 0; c < 4; c++)
								for (int l = 0; l < 4; l++) begin
									av = aw[r][8*l +: 8];
									bv = bw[l][8*c +: 8];
									acc[r][c] += av * bv;
								end
					end
					for (int r = 0; r < 4; r++)
						for (int c = 0; c < 4; c++) begin
							e.sum = acc[r][c];
							e.row = POS_W'(row0 + r);
							e.col = POS_W'(col0 + c);
							e.last = (r == 3 && c == 3);
							pending_sums.push_back(e);
						end
					tiles_run++;
				end
				default: ;
			endcase
		endfunction

		function void check_sum(c_elem_t got);
			c_elem_t want;
			if (pending_sums.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected beat, expected none, got sum %0d row %0d col %0d last %0b",
					$time, $signed(got.sum), got.row, got.col, got.last);
				return;
			end
			want = pending_sums.pop_front();
			sums_checked++;
			if (got.sum !== want.sum) begin
				mismatches++;
				$display("%0t: sum_value expected %0d got %0d", $time, $signed(want.sum),
					$signed(got.sum));
			end
			if (got.row !== want.row) begin
				mismatches++;
				$display("%0t: out_row expected %0d got %0d", $time, want.row, got.row);
			end
			if (got.col !== want.col) begin
				mismatches++;
				$display("%0t: out_col expected %0d got %0d", $time, want.col, got.col);
			end
			if (got.last !== want.last) begin
				mismatches++;
				$display("%0t: last expected %0b got %0b", $time, want.last, got.last);
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic [KIND_W-1:0]      s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [APB_ADDR_W-1:0]  paddr;
	logic [APB_DATA_W-1:0]  pwdata;
	logic [APB_DATA_W-1:0]  prdata;
	logic                   pready;

	matmul_predictor pred;
	bit burst = 0;
	int stall_cycles = 0;
	int cycles = 0;

	int8_tiled_matrix_multiply uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [WIDX_W-1:0] widx,
			input logic [DATA_W-1:0] word, input logic [TILE_W-1:0] tr,
			input logic [TILE_W-1:0] tc);
		int gap;
		logic [IN_TDATA_W-1:0] beat;
		gap = burst ? 0 : $urandom_range(0, 3);
		beat = '0;
		beat[IN_WIDX_LSB +: WIDX_W] = widx;
		beat[IN_DATA_LSB +: DATA_W] = word;
		beat[IN_TROW_LSB +: TILE_W] = tr;
		beat[IN_TCOL_LSB +: TILE_W] = tc;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= beat;
		do @(posedge clk); while (s_tready !== 1'b1);
		pred.note_beat(kind, widx, word, tr, tc);
	endtask

	// drop valid, wait out every pending sum, then give silent work time to finish
	task automatic settle(input int extra);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pred.pending_sums.size() != 0) @(negedge clk);
		repeat (extra) @(negedge clk);
	endtask

	task automatic set_reg(input dim_reg_e idx, input logic [DIM_W-1:0] v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_W'(int'(idx) * 4);
		pwdata <= APB_DATA_W'(v);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pred.set_dim(idx, v);
	endtask

	task automatic set_dims(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] k,
			input logic [DIM_W-1:0] c);
		set_reg(REG_ROWS_A, r);
		set_reg(REG_INNER_LEN, k);
		set_reg(REG_COLS_B, c);
	endtask

	task automatic random_item();
		int pick;
		logic [TILE_W-1:0] tr, tc;
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			tr = TILE_W'($urandom_range(0, pred.rows_eff / 4 - 1));
			tc = TILE_W'($urandom_range(0, pred.cols_eff / 4 - 1));
			send_beat(KIND_TILE, WIDX_W'($urandom_range(0, 1023)), $urandom, tr, tc);
		end else if (pick < 60) begin
			send_beat(KIND_TILE, WIDX_W'($urandom_range(0, 1023)), $urandom,
				TILE_W'($urandom_range(0, 15)), TILE_W'($urandom_range(0, 15)));
		end else if (pick < 95) begin
			send_beat((pick < 78) ? KIND_WR_A : KIND_WR_B, WIDX_W'($urandom_range(0, 1023)),
				$urandom, TILE_W'($urandom_range(0, 15)), TILE_W'($urandom_range(0, 15)));
		end else begin
			send_beat(KIND_UNUSED, WIDX_W'($urandom_range(0, 1023)), $urandom,
				TILE_W'($urandom_range(0, 15)), TILE_W'($urandom_range(0, 15)));
		end
	endtask

	// result side: random backpressure, long hold-off on request
	initial begin
		int gap;
		c_elem_t got;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (stall_cycles) @(negedge clk);
				stall_cycles = 0;
			end
			gap = burst ? 0 : $urandom_range(0, 3);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			got.sum = m_tdata[OUT_SUM_LSB +: SUM_W];
			got.row = m_tdata[OUT_ROW_LSB +: POS_W];
			got.col = m_tdata[OUT_COL_LSB +: POS_W];
			got.last = m_tlast;
			pred.check_sum(got);
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("%0t: timeout after %0d cycles", $time, cycles);
		$display("[int8_tiled_matrix_multiply] ERROR");
		$finish;
	end

	initial begin
		int settings_used;
		logic [DIM_W-1:0] dr, dk, dc;
		settings_used = 0;
		pred = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// fill the low words of both stores so that every tile reads written words
		for (int i = 0; i < FILL_WORDS; i++) begin
			send_beat(KIND_WR_A, WIDX_W'(i), $urandom, TILE_W'($urandom_range(0, 15)),
				TILE_W'($urandom_range(0, 15)));
			send_beat(KIND_WR_B, WIDX_W'(i), $urandom, TILE_W'($urandom_range(0, 15)),
				TILE_W'($urandom_range(0, 15)));
		end
		settle(TILE_LATENCY);

		// odd register values round down and clamp to a 4x4x4 problem
		set_dims(7'd3, 7'd2, 7'd1);
		settings_used++;
		for (int i = 0; i < 4; i++) send_beat(KIND_WR_A, WIDX_W'(i), 32'h8080_8080, 4'd0, 4'd0);
		for (int i = 0; i < 4; i++) send_beat(KIND_WR_B, WIDX_W'(i), 32'h8080_8080, 4'd0, 4'd0);
		send_beat(KIND_TILE, '0, '0, 4'd0, 4'd0);
		for (int i = 0; i < 4; i++) send_beat(KIND_WR_B, WIDX_W'(i), 32'h7F7F_7F7F, 4'd0, 4'd0);
		send_beat(KIND_TILE, '0, '0, 4'd0, 4'd0);
		send_beat(KIND_WR_A, 10'd0, 32'h0000_0000, 4'd0, 4'd0);
		send_beat(KIND_WR_A, 10'd1, 32'hFFFF_FFFF, 4'd0, 4'd0);
		send_beat(KIND_TILE, '0, '0, 4'd0, 4'd0);
		// tiles past the matrix edge and the unused kind yield nothing
		send_beat(KIND_TILE, '0, '0, 4'd1, 4'd0);
		send_beat(KIND_TILE, '0, '0, 4'd0, 4'd15);
		send_beat(KIND_UNUSED, 10'h3FF, 32'hFFFF_FFFF, 4'd15, 4'd15);
		send_beat(KIND_WR_A, 10'h3FF, 32'hFFFF_FFFF, 4'd15, 4'd15);
		send_beat(KIND_WR_B, 10'h3FF, 32'h8000_0001, 4'd15, 4'd15);
		settle(TILE_LATENCY);

		// oversized rows and columns clamp to 64; the far corner tile reads A 60..63
		// and B 15, 31, 47, 63
		set_dims(7'd127, 7'd1, 7'd127);
		settings_used++;
		for (int i = 60; i < 64; i++) send_beat(KIND_WR_A, WIDX_W'(i), $urandom, 4'd0, 4'd0);
		send_beat(KIND_WR_B, 10'd47, $urandom, 4'd0, 4'd0);
		send_beat(KIND_WR_B, 10'd63, $urandom, 4'd0, 4'd0);
		send_beat(KIND_TILE, '0, '0, 4'd15, 4'd15);

		for (int p = 0; p < 4; p++) begin
			// at most 16 rows, inner 8 and 16 columns: every read stays in the filled words
			dr = DIM_W'($urandom_range(0, 19));
			dk = DIM_W'($urandom_range(0, 11));
			dc = DIM_W'($urandom_range(0, 19));
			settle(TILE_LATENCY);
			set_dims(dr, dk, dc);
			settings_used++;
			// hold the result side so the block fills and stalls its input
			if (p == 1) stall_cycles = 400;
			burst = (p == 1 || p == 2);
			for (int i = 0; i < 18; i++) begin
				if (p == 3 && i == 9) settle(0);
				random_item();
			end
			burst = 0;
		end

		settle(TILE_LATENCY);
		$display("Run covered %0d store writes and %0d tiles over %0d dimension settings,",
			pred.words_written, pred.tiles_run, settings_used);
		$display("with %0d sums checked and %0d mismatches.", pred.sums_checked,
			pred.mismatches);
		if (pred.mismatches == 0) begin
			$display("[int8_tiled_matrix_multiply] OK");
		end else begin
			$display("[int8_tiled_matrix_multiply] ERROR");
		end
		$finish;
	end

endmodule

FILE: int8_tiled_matrix_multiply.f
rtl/i8mm_pkg.sv
rtl/i8mm_ram.sv
rtl/i8mm_cfg.sv
rtl/i8mm_ctrl.sv
rtl/i8mm_dp.sv
rtl/int8_tiled_matrix_multiply.sv
rtl/i8mm_checker.sv
bench/tb_int8_tiled_matrix_multiply.sv
